// File: sv/dpm_pkg.sv
// Shared constants, types and the pressure table for the delta performance monitor.
package dpm_pkg;

  // Field widths
  localparam int DELTA_W  = 16;
  localparam int PRESS_W  = 20;
  localparam int TIME_W   = 32;
  localparam int FACTOR_W = 10;
  localparam int MINOUT_W = 21;

  // Defaults
  localparam int RING_DEPTH_DEF = 8;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 10'd256;

  // Pressure limits in Q10 Torr
  localparam logic [PRESS_W-1:0] P_TOP_Q10   = 20'd9728;   // 9.5 Torr
  localparam logic [PRESS_W-1:0] P_BOT_Q10   = 20'd512;    // 0.5 Torr
  localparam logic [PRESS_W-1:0] P_LIMIT_Q10 = 20'd10240;  // 10 Torr
  localparam logic [TIME_W:0]    MIN_INTERVAL = 33'd10;

  // Interpolation widths
  localparam int TIDX_W  = 5;   // table index
  localparam int TVAL_W  = 11;  // table delta
  localparam int DIST_W  = 10;  // distance to upper point, 0..512
  localparam int NUM_W   = 20;  // interpolated delta times 512
  localparam int NF_W    = NUM_W + FACTOR_W;
  localparam int NFF_W   = NF_W + FACTOR_W;
  localparam int MINQ8_W = NFF_W - 17;

  // Input command codes
  typedef enum logic {
    CMD_CLEAR  = 1'b0,
    CMD_SAMPLE = 1'b1
  } dpm_cmd_t;

  // Divider status toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } dpm_div_stat_t;

  // Minimum delta at 9.5, 9.0 .. 0.5 Torr
  function automatic logic [TVAL_W-1:0] tbl_delta(input logic [TIDX_W-1:0] idx);
    logic [TVAL_W-1:0] val;
    case (idx)
      5'd0:    val = 11'd1080;
      5'd1:    val = 11'd1023;
      5'd2:    val = 11'd920;
      5'd3:    val = 11'd825;
      5'd4:    val = 11'd755;
      5'd5:    val = 11'd673;
      5'd6:    val = 11'd591;
      5'd7:    val = 11'd516;
      5'd8:    val = 11'd445;
      5'd9:    val = 11'd376;
      5'd10:   val = 11'd318;
      5'd11:   val = 11'd263;
      5'd12:   val = 11'd209;
      5'd13:   val = 11'd161;
      5'd14:   val = 11'd118;
      5'd15:   val = 11'd82;
      5'd16:   val = 11'd51;
      5'd17:   val = 11'd27;
      5'd18:   val = 11'd13;
      default: val = 11'd0;
    endcase
    return val;
  endfunction

endpackage

// File: sv/dpm_div.sv
// Restoring divider, one quotient bit per cycle.
module dpm_div
  import dpm_pkg::*;
#(
  parameter int DVD_W = 26,
  parameter int DVS_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output dpm_div_stat_t    stat
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVS_W:0]    rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0]    shifted;
  logic              q_bit;
  logic [DVS_W:0]    rem_nxt;

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    shifted = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
    q_bit   = (shifted >= {1'b0, dvs_r});
    rem_nxt = q_bit ? (shifted - {1'b0, dvs_r}) : shifted;
  end

  // Control: step count and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], q_bit};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: sv/delta_performance_monitor.sv
// Top level of the delta performance monitor: ring memory, control and minimum-delta datapath.
//
// Usage:
//   in_*  : one request per sample or clear. in_tuser is the command (0 clears the ring
//           and sets performing, 1 offers a sample); in_tdata carries delta, pressure (Q10
//           Torr) and the seconds counter.
//   out_* : one result per request: performing flag, accepted flag, truncated mean of the stored
//           deltas (-1 when empty) and the scaled minimum delta (-1 out of range or factor 0).
//   cfg_* : cfg_we writes cfg_wdata into the Q8 minimum factor; write only while idle.
// Timing: out_tvalid rises after S_READ, S_UPDATE, S_DIV and S_OUT; S_DIV lasts as long as
//   the bit-serial divider that forms the Q8 mean, one quotient bit per cycle.
//   One request is in work at a time; in_tready is high only while idle, so a new request
//   is taken only once the previous one has left S_OUT.
// The ring memory is written once per accepted sample; the running sum of the stored
//   deltas is kept in a register and updated from the entry being replaced.
// Reset: ring empty, performing set, last sample time zero, factor 256 (1.0).
//   Ring contents are not cleared; only entries written since the last clear are counted.
// Stall: the result waits in the output register; the next request may be accepted
//   meanwhile, and its result is held back until the previous one is taken.
module delta_performance_monitor
  import dpm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [71:0]         in_tdata,   // delta[15:0], pressure[35:16], now_seconds[67:36]
  input  logic                in_tuser,   // cmd
  // Result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // performing[0], accepted[1],
                                          // average_delta[17:2], minimum_delta[38:18]
  // Configuration
  input  logic                cfg_we,
  input  logic [FACTOR_W-1:0] cfg_wdata
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = DELTA_W - 1 + $clog2(RING_DEPTH);
  localparam int DVD_W = SUM_W + 8;
  localparam int CMP_W = (DVD_W > MINQ8_W) ? DVD_W : MINQ8_W;
  localparam int PD_W  = 14;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV,
    S_OUT
  } state_t;

  state_t               state_r;
  logic [FACTOR_W-1:0]  factor_r;
  logic [IDX_W-1:0]     slot_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 perf_r;
  logic [TIME_W-1:0]    last_r;
  logic                 acc_r;
  logic                 out_tvalid_r;
  logic [39:0]          out_tdata_r;

  // Latched request
  logic                 cmd_r;
  logic [DELTA_W-1:0]   delta_r;
  logic [PRESS_W-1:0]   press_r;
  logic [TIME_W-1:0]    now_r;

  // Ring memory
  logic [DELTA_W-1:0]   ring_mem [RING_DEPTH];
  logic [DELTA_W-1:0]   rd_data_r;
  logic                 mem_we;

  // Minimum-delta pipeline
  logic [PD_W-1:0]      pdiff;
  logic [TIDX_W-1:0]    tidx;
  logic [DIST_W-1:0]    p_dist;
  logic [TVAL_W-1:0]    dd;
  logic [NUM_W-1:0]     mul1_r;
  logic [NUM_W-1:0]     num_r;
  logic [NF_W-1:0]      nf_r;
  logic [NFF_W-1:0]     nff_r;
  logic                 min_ok;
  logic [MINQ8_W-1:0]   min_q8;
  logic [MINOUT_W-1:0]  min_whole;

  // Update and divide
  logic                 sample_ok;
  logic                 is_clear;
  logic [SUM_W-1:0]     sum_nxt;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [IDX_W-1:0]     slot_nxt;
  logic                 full;
  logic                 div_start;
  logic [DVD_W-1:0]     mean_q8;
  dpm_div_stat_t        div_stat;
  logic                 perf_nxt;
  logic [DELTA_W-1:0]   avg_out;
  logic                 out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign is_clear   = (cmd_r == CMD_CLEAR);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RESET;
    end else if (cfg_we) begin
      factor_r <= cfg_wdata;
    end
  end

  // Latch the request on accept
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_tuser;
      delta_r <= in_tdata[15:0];
      press_r <= in_tdata[35:16];
      now_r   <= in_tdata[67:36];
    end
  end

  // Locate the table segment holding the pressure
  always_comb begin
    pdiff  = PD_W'(P_TOP_Q10 - press_r);
    tidx   = (pdiff == '0) ? '0 : TIDX_W'((pdiff - 1'b1) >> 9);
    p_dist = DIST_W'(pdiff - {tidx, 9'b0});
    dd     = tbl_delta(tidx) - tbl_delta(tidx + 1'b1);
  end

  // Interpolate and scale twice by the factor, at most one multiply per stage
  always_ff @(posedge clk) begin
    mul1_r <= NUM_W'(p_dist) * NUM_W'(dd);
    num_r  <= NUM_W'({tbl_delta(tidx), 9'b0}) - mul1_r;
    nf_r   <= num_r * factor_r;
    nff_r  <= nf_r * factor_r;
  end

  always_comb begin
    min_ok    = (press_r >= P_BOT_Q10) && (press_r <= P_TOP_Q10) &&
                (factor_r != '0) && (num_r != '0);
    min_q8    = nff_r[NFF_W-1:17];
    min_whole = min_ok ? MINOUT_W'(nff_r[NFF_W-1:25]) : '1;
  end

  // Sample admission and ring bookkeeping
  always_comb begin
    full      = (cnt_r == CNT_W'(RING_DEPTH));
    sample_ok = (cmd_r == CMD_SAMPLE) && perf_r && !delta_r[DELTA_W-1] &&
                (press_r <= P_LIMIT_Q10) &&
                ({1'b0, now_r} >= ({1'b0, last_r} + MIN_INTERVAL));
    sum_nxt   = SUM_W'(sum_r + SUM_W'(delta_r) - (full ? SUM_W'(rd_data_r) : '0));
    cnt_nxt   = full ? cnt_r : CNT_W'(cnt_r + 1'b1);
    slot_nxt  = (slot_r == IDX_W'(RING_DEPTH - 1)) ? '0 : IDX_W'(slot_r + 1'b1);
    mem_we    = (state_r == S_UPDATE) && !is_clear && sample_ok;
    div_start = (state_r == S_UPDATE);
  end

  // Ring memory: write the new delta, read the entry it replaces
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[slot_r] <= delta_r;
    end
    rd_data_r <= ring_mem[slot_r];
  end

  // Q8 mean of the stored deltas
  dpm_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (is_clear ? '0 : {(mem_we ? sum_nxt : sum_r), 8'b0}),
    .divisor  (is_clear ? '0 : (mem_we ? cnt_nxt : cnt_r)),
    .quotient (mean_q8),
    .stat     (div_stat)
  );

  // New flag and result fields
  always_comb begin
    perf_nxt = perf_r;
    if (acc_r) begin
      perf_nxt = !min_ok || (CMP_W'(mean_q8) > CMP_W'(min_q8));
    end
    avg_out = (cnt_r == '0) ? '1 : DELTA_W'(mean_q8 >> 8);
  end

  // Controller
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_r       <= '0;
      cnt_r        <= '0;
      sum_r        <= '0;
      perf_r       <= 1'b1;
      last_r       <= '0;
      acc_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // drop the result once taken
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          acc_r <= !is_clear && sample_ok;
          if (is_clear) begin
            slot_r <= '0;
            cnt_r  <= '0;
            sum_r  <= '0;
            perf_r <= 1'b1;
          end else if (sample_ok) begin
            slot_r <= slot_nxt;
            cnt_r  <= cnt_nxt;
            sum_r  <= sum_nxt;
            last_r <= now_r;
          end
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            perf_r       <= perf_nxt;
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {1'b0, min_whole, avg_out, acc_r, perf_nxt};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Stored count never passes the ring depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RING_DEPTH))
    else $error("stored count above ring depth");

  // Until the ring fills, the write slot follows the count
  a_slot_tracks_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < CNT_W'(RING_DEPTH)) |-> (slot_r == IDX_W'(cnt_r)))
    else $error("write slot out of step with stored count");

  // No request is taken while the divider still works
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("request accepted while divider busy");

  // An accepted sample always enters the ring with performing set beforehand
  a_acc_perf: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (acc_r && $past(perf_r)))
    else $error("sample stored while not performing");
`endif

endmodule
